FILE: design/pits_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Task scheduler package
// Shared types, codes and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package pits_pkg;

  localparam int MAX_TASKS_DEF = 64;
  localparam int CFG_W         = 7;
  localparam int FUNC_W        = 3;
  localparam int PRIO_W        = 3;
  localparam int KEY_W         = 32;
  localparam int TICK_W        = 8;

  localparam logic [CFG_W-1:0]  MAX_TASKS_RST = 7'd64;
  localparam logic [PRIO_W-1:0] PRIO_TOP      = 3'd4;
  localparam logic [PRIO_W-1:0] PRIO_IDLE     = 3'd0;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK     = 3'd0,
    FN_DISPATCH = 3'd1,
    FN_ADD      = 3'd2,
    FN_REMOVE   = 3'd3,
    FN_UPDATE   = 3'd4,
    FN_GET      = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_TIMED = 2'd1,
    KIND_IDLE  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [KEY_W-1:0]  code;
    logic [KEY_W-1:0]  arg;
    logic [KEY_W-1:0]  ivl;
    logic [PRIO_W-1:0] prio;
    logic [KEY_W-1:0]  elapsed;
  } entry_t;

  typedef struct packed {
    kind_t  kind;
    logic   ok;
    entry_t ent;
  } row_t;

  typedef enum logic [2:0] {
    IDX_HOLD, IDX_ZERO, IDX_TIMED, IDX_LIVE, IDX_INC, IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {RD_IDX, RD_IDX_P1, RD_IDX_M1} rd_sel_t;

  typedef enum logic [2:0] {WR_COPY, WR_FOLD, WR_DISP, WR_NEW, WR_UPD} wr_sel_t;

  typedef enum logic [1:0] {CNT_HOLD, CNT_ADD, CNT_REMOVE} cnt_op_t;

  typedef enum logic [2:0] {
    ROW_REPLY, ROW_GET, ROW_TIMED, ROW_IDLE, ROW_NONE
  } row_sel_t;

  typedef struct packed {
    logic     load_req;
    idx_op_t  idx_op;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wr_sel_t  wr_sel;
    logic     latch_ticks;
    logic     tick_inc;
    cnt_op_t  cnt_op;
    logic     row_push;
    row_sel_t row_sel;
    logic     row_ok;
    logic     flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic code_zero;
    logic pend_nz;
    logic match;
    logic idx_zero;
    logic idx_ge_live;
    logic idx_ge_timed;
    logic full;
    logic prio_bad;
    logic new_gt;
    logic ent_bad;
    logic class_empty;
    logic expire;
    logic push_ok;
    logic hold_v;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: design/pits_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pits_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic [WIDTH-1:0]      wr_data,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_addr,
  output logic      [WIDTH-1:0]      rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

FILE: design/pits_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Task scheduler datapath
// Task table RAM, walk index, counters, request and result registers.
// ----------------------------------------------------------------------------
module pits_dp
  import pits_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctl_cmd_t          cmd,
  output dp_stat_t               stat,
  input  wire logic [FUNC_W-1:0] in_func,
  input  wire logic [KEY_W-1:0]  in_code,
  input  wire logic [KEY_W-1:0]  in_arg,
  input  wire logic [KEY_W-1:0]  in_ivl,
  input  wire logic [PRIO_W-1:0] in_prio,
  input  wire logic              cfg_we,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output row_t                   out_row,
  output logic                   out_last
);
  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int EW = $bits(entry_t);

  logic [FUNC_W-1:0] req_func;
  logic [KEY_W-1:0]  req_code, req_arg, req_ivl;
  logic [PRIO_W-1:0] req_prio;
  logic [CW-1:0]     idx, timed_cnt, idle_cnt;
  logic [TICK_W-1:0] pending, tks;
  logic [CFG_W-1:0]  max_tasks;
  logic              hold_v;
  row_t              hold;

  logic [CW-1:0]     live, idx_p1, idx_m1, rd_idx;
  logic [CFG_W-1:0]  cap;
  logic [EW-1:0]     rd_data, wr_data;
  entry_t            rd_ent, wr_ent;
  logic [KEY_W-1:0]  sum;
  logic              expire, out_free;
  row_t              new_row;

  assign live   = timed_cnt + idle_cnt;
  assign idx_p1 = idx + CW'(1);
  assign idx_m1 = idx - CW'(1);
  assign rd_ent = entry_t'(rd_data);
  assign sum    = rd_ent.elapsed + KEY_W'(tks);
  assign expire = (sum >= rd_ent.ivl);
  assign cap    = (max_tasks > CFG_W'(MAX_TASKS)) ? CFG_W'(MAX_TASKS) : max_tasks;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX_P1: rd_idx = idx_p1;
      RD_IDX_M1: rd_idx = idx_m1;
      default:   rd_idx = idx;
    endcase
  end

  always_comb begin
    wr_ent = rd_ent;
    case (cmd.wr_sel)
      WR_FOLD: wr_ent.elapsed = sum;
      WR_DISP: wr_ent.elapsed = expire ? '0 : sum;
      WR_NEW: begin
        wr_ent.code    = req_code;
        wr_ent.arg     = req_arg;
        wr_ent.ivl     = req_ivl;
        wr_ent.prio    = req_prio;
        wr_ent.elapsed = '0;
      end
      WR_UPD: begin
        wr_ent.ivl     = req_ivl;
        wr_ent.prio    = req_prio;
        wr_ent.elapsed = '0;
      end
      default: wr_ent = rd_ent;
    endcase
  end
  assign wr_data = EW'(wr_ent);

  pits_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (idx[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    new_row      = '0;
    new_row.ok   = 1'b1;
    case (cmd.row_sel)
      ROW_REPLY: begin
        new_row.kind = KIND_REPLY;
        new_row.ok   = cmd.row_ok;
      end
      ROW_GET: begin
        new_row.kind = KIND_REPLY;
        new_row.ent  = rd_ent;
      end
      ROW_TIMED: begin
        new_row.kind            = KIND_TIMED;
        new_row.ent             = rd_ent;
        new_row.ent.elapsed     = sum;
      end
      ROW_IDLE: begin
        new_row.kind = KIND_IDLE;
        new_row.ent  = rd_ent;
      end
      default: new_row.kind = KIND_NONE;
    endcase
  end

  always_comb begin
    stat              = '0;
    stat.func         = req_func;
    stat.code_zero    = (req_code == '0);
    stat.pend_nz      = (pending != '0);
    stat.match        = (rd_ent.code == req_code) &&
                        ((req_arg == '0) || (rd_ent.arg == req_arg));
    stat.idx_zero     = (idx == '0);
    stat.idx_ge_live  = (idx >= live);
    stat.idx_ge_timed = (idx >= timed_cnt);
    stat.full         = (CFG_W'(live) >= cap);
    stat.prio_bad     = (req_prio > PRIO_TOP);
    stat.new_gt       = (req_prio > rd_ent.prio);
    stat.ent_bad      = (rd_ent.prio > PRIO_TOP);
    stat.class_empty  = (rd_ent.prio == PRIO_IDLE) ? (idle_cnt == '0) : (timed_cnt == '0);
    stat.expire       = expire;
    stat.push_ok      = !hold_v || out_free;
    stat.hold_v       = hold_v;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_func <= in_func;
      req_code <= in_code;
      req_arg  <= in_arg;
      req_ivl  <= in_ivl;
      req_prio <= in_prio;
    end
    if (cmd.row_push) begin
      hold <= new_row;
      if (hold_v) begin
        out_row  <= hold;
        out_last <= 1'b0;
      end
    end else if (cmd.flush) begin
      out_row  <= hold;
      out_last <= 1'b1;
    end
    if (cmd.latch_ticks) begin
      tks <= pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      timed_cnt <= '0;
      idle_cnt  <= '0;
      pending   <= '0;
      max_tasks <= MAX_TASKS_RST;
      hold_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_tasks <= cfg_wdata;
      end
      case (cmd.idx_op)
        IDX_ZERO:  idx <= '0;
        IDX_TIMED: idx <= timed_cnt;
        IDX_LIVE:  idx <= live;
        IDX_INC:   idx <= idx_p1;
        IDX_DEC:   idx <= idx_m1;
        default:   idx <= idx;
      endcase
      case (cmd.cnt_op)
        CNT_ADD: begin
          if (req_prio == PRIO_IDLE) idle_cnt <= idle_cnt + CW'(1);
          else                       timed_cnt <= timed_cnt + CW'(1);
        end
        CNT_REMOVE: begin
          if (rd_ent.prio == PRIO_IDLE) idle_cnt <= idle_cnt - CW'(1);
          else                          timed_cnt <= timed_cnt - CW'(1);
        end
        default: ;
      endcase
      if (cmd.latch_ticks) begin
        pending <= '0;
      end else if (cmd.tick_inc) begin
        pending <= pending + TICK_W'(1);
      end
      // load the output register from the hold stage, else drop it once taken
      if (cmd.flush || (cmd.row_push && hold_v)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.row_push) begin
        hold_v <= 1'b1;
      end else if (cmd.flush) begin
        hold_v <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/pits_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Task scheduler controller
// Sequences lookup, tick fold, insertion, removal shift and dispatch walks.
// ----------------------------------------------------------------------------
module pits_ctrl
  import pits_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);
  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_F_CHK, S_F_CMP, S_A_CAP, S_A_FCHK, S_A_FWR, S_A_PRIO,
    S_A_ICHK, S_A_ICMP, S_R_CHK, S_R_SCHK, S_R_SWR, S_T_CHK, S_T_EVAL,
    S_I_CHK, S_I_EMIT, S_D_END, S_FLUSH
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.idx_op = IDX_HOLD;
    cmd.cnt_op = CNT_HOLD;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.func)
          FN_TICK: begin
            cmd.tick_inc = 1'b1;
            cmd.row_push = 1'b1;
            cmd.row_ok   = 1'b1;
            state_next   = S_FLUSH;
          end
          FN_DISPATCH: begin
            if (stat.pend_nz) begin
              cmd.latch_ticks = 1'b1;
              cmd.idx_op      = IDX_ZERO;
              state_next      = S_T_CHK;
            end else begin
              cmd.idx_op = IDX_TIMED;
              state_next = S_I_CHK;
            end
          end
          FN_ADD, FN_REMOVE, FN_UPDATE, FN_GET: begin
            cmd.idx_op = IDX_ZERO;
            state_next = S_F_CHK;
          end
          default: begin
            cmd.row_push = 1'b1;
            state_next   = S_FLUSH;
          end
        endcase
      end
      // lookup walk: read an entry in S_F_CHK, compare it in S_F_CMP
      S_F_CHK: begin
        if (stat.code_zero || stat.idx_ge_live) begin
          if (stat.func == FN_ADD && !stat.code_zero) begin
            state_next = S_A_CAP;
          end else begin
            cmd.row_push = 1'b1;
            state_next   = S_FLUSH;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_F_CMP;
        end
      end
      S_F_CMP: begin
        if (stat.match) begin
          case (stat.func)
            FN_REMOVE: state_next = S_R_CHK;
            FN_UPDATE: begin
              cmd.wr_en    = 1'b1;
              cmd.wr_sel   = WR_UPD;
              cmd.row_push = 1'b1;
              cmd.row_ok   = 1'b1;
              state_next   = S_FLUSH;
            end
            FN_GET: begin
              cmd.row_push = 1'b1;
              cmd.row_sel  = ROW_GET;
              state_next   = S_FLUSH;
            end
            default: begin
              cmd.row_push = 1'b1;
              state_next   = S_FLUSH;
            end
          endcase
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_F_CHK;
        end
      end
      S_A_CAP: begin
        if (stat.full) begin
          cmd.row_push = 1'b1;
          state_next   = S_FLUSH;
        end else begin
          cmd.latch_ticks = 1'b1;
          cmd.idx_op      = IDX_ZERO;
          state_next      = S_A_FCHK;
        end
      end
      S_A_FCHK: begin
        if (stat.idx_ge_timed) begin
          state_next = S_A_PRIO;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_A_FWR;
        end
      end
      S_A_FWR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_FOLD;
        cmd.idx_op = IDX_INC;
        state_next = S_A_FCHK;
      end
      S_A_PRIO: begin
        if (stat.prio_bad) begin
          cmd.row_push = 1'b1;
          state_next   = S_FLUSH;
        end else begin
          cmd.idx_op = IDX_LIVE;
          cmd.cnt_op = CNT_ADD;
          state_next = S_A_ICHK;
        end
      end
      // insertion: move lower-priority entries up until the slot is found
      S_A_ICHK: begin
        if (stat.idx_zero) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WR_NEW;
          cmd.row_push = 1'b1;
          cmd.row_ok   = 1'b1;
          state_next   = S_FLUSH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
          state_next = S_A_ICMP;
        end
      end
      S_A_ICMP: begin
        cmd.wr_en = 1'b1;
        if (stat.new_gt) begin
          cmd.wr_sel = WR_COPY;
          cmd.idx_op = IDX_DEC;
          state_next = S_A_ICHK;
        end else begin
          cmd.wr_sel   = WR_NEW;
          cmd.row_push = 1'b1;
          cmd.row_ok   = 1'b1;
          state_next   = S_FLUSH;
        end
      end
      S_R_CHK: begin
        if (stat.ent_bad || stat.class_empty) begin
          cmd.row_push = 1'b1;
          state_next   = S_FLUSH;
        end else begin
          cmd.cnt_op = CNT_REMOVE;
          state_next = S_R_SCHK;
        end
      end
      // close the gap: pull each following entry down by one
      S_R_SCHK: begin
        if (stat.idx_ge_live) begin
          cmd.row_push = 1'b1;
          cmd.row_ok   = 1'b1;
          state_next   = S_FLUSH;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_P1;
          state_next = S_R_SWR;
        end
      end
      S_R_SWR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_COPY;
        cmd.idx_op = IDX_INC;
        state_next = S_R_SCHK;
      end
      S_T_CHK: begin
        if (stat.idx_ge_timed) begin
          state_next = S_D_END;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_T_EVAL;
        end
      end
      S_T_EVAL: begin
        // hold until the result stage has room for an expired task
        if (!stat.expire || stat.push_ok) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WR_DISP;
          cmd.idx_op   = IDX_INC;
          cmd.row_push = stat.expire;
          cmd.row_sel  = ROW_TIMED;
          state_next   = S_T_CHK;
        end
      end
      S_I_CHK: begin
        if (stat.idx_ge_live) begin
          state_next = S_D_END;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_I_EMIT;
        end
      end
      S_I_EMIT: begin
        if (stat.push_ok) begin
          cmd.row_push = 1'b1;
          cmd.row_sel  = ROW_IDLE;
          cmd.idx_op   = IDX_INC;
          state_next   = S_I_CHK;
        end
      end
      S_D_END: begin
        if (!stat.hold_v) begin
          cmd.row_push = 1'b1;
          cmd.row_sel  = ROW_NONE;
        end
        state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (stat.push_ok) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule
`default_nettype wire

FILE: design/priority_interval_task_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority interval task scheduler
// Priority-sorted periodic task table with tick, dispatch, add, remove,
// update and get requests.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  s_axis  | in        | s_axis_tvalid/tready    | tuser func, tdata task fields
//  m_axis  | out       | m_axis_tvalid/tready    | tuser kind, tdata row, tlast
//  cfg     | in        | cfg_valid/cfg_ready     | cfg_data max_tasks
//
//  One request at a time. The table sits in one RAM; each walk step reads an
//  entry, then compares, writes or emits it.
//  Reset clears the counters and output state; the table needs no clearing pass.
//  Result rows pass a one-row hold stage and an output register, so a full
//  output stalls only the walk step that produces a row and the final flush.
// ----------------------------------------------------------------------------
module priority_interval_task_scheduler
  import pits_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] task_code, [63:32] task_arg, [95:64] interval, [98:96] priority_req
  input  wire logic [103:0] s_axis_tdata,
  // [2:0] func
  input  wire logic [2:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [0] ok, [32:1] out_code, [64:33] out_arg, [96:65] out_interval,
  // [99:97] out_priority, [131:100] out_elapsed
  output logic [135:0]      m_axis_tdata,
  // [1:0] kind
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [6:0]   cfg_data
);
  ctl_cmd_t cmd;
  dp_stat_t stat;
  row_t     out_row;

  assign cfg_ready = 1'b1;

  pits_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pits_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_func   (s_axis_tuser),
    .in_code   (s_axis_tdata[31:0]),
    .in_arg    (s_axis_tdata[63:32]),
    .in_ivl    (s_axis_tdata[95:64]),
    .in_prio   (s_axis_tdata[98:96]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_wdata (cfg_data),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_row   (out_row),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tuser = out_row.kind;
  assign m_axis_tdata = {4'b0, out_row.ent.elapsed, out_row.ent.prio, out_row.ent.ivl,
                         out_row.ent.arg, out_row.ent.code, out_row.ok};

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_en && cmd.rd_en))
    else $error("table read and write in the same cycle");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.row_push || cmd.flush) |-> stat.push_ok)
    else $error("result row pushed without room");

  a_none_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_NONE) |-> m_axis_tlast)
    else $error("nothing-ran row not marked last");
endmodule
`default_nettype wire
